// ----- rtl/next_fit_slot_allocator_defines.svh -----
// Assertion macros shared by the checker.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define NFSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfsa check failed");

// Next-cycle implication, gated off during reset.
`define NFSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfsa check failed");

`endif

// ----- rtl/nfsa_pkg.sv -----
package nfsa_pkg;

  localparam int SLOTS_DEF = 16;

  // Field widths of the item ports
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_AFREE = 2'd3
  } status_t;

  // What the response state commits to the pool
  typedef enum logic [1:0] {
    K_NONE    = 2'd0,
    K_ALLOC   = 2'd1,
    K_RELEASE = 2'd2
  } kind_t;

  typedef struct packed {
    logic    clr_step;
    logic    accept;
    logic    rd_scan;
    logic    scan_start;
    logic    scan_step;
    logic    res_load;
    status_t res_code;
    kind_t   res_kind;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_alloc;
    logic full;
    logic empty;
    logic idx_oob;
    logic chk_free;
    logic scan_hit;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/nfsa_ram.sv -----
module nfsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/nfsa_ctrl.sv -----
module nfsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nfsa_pkg::sts_t sts,
  output nfsa_pkg::cmd_t cmd
);

  import nfsa_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_DECODE  = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_REL_RD  = 7'b0010000,
    S_REL_CHK = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.req_alloc) begin
          if (sts.full) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_FULL;
            cmd.res_kind = K_NONE;
            state_nxt    = S_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.empty) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_EMPTY;
          cmd.res_kind = K_NONE;
          state_nxt    = S_RESP;
        end else if (sts.idx_oob) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_AFREE;
          cmd.res_kind = K_NONE;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_REL_RD;
        end
      end
      S_REL_RD: begin
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        cmd.res_load = 1'b1;
        if (sts.chk_free) begin
          cmd.res_code = ST_AFREE;
          cmd.res_kind = K_NONE;
        end else begin
          cmd.res_code = ST_OK;
          cmd.res_kind = K_RELEASE;
        end
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.rd_scan   = 1'b1;
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_kind = K_ALLOC;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/nfsa_dp.sv -----
module nfsa_dp #(
  parameter int SLOTS = nfsa_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nfsa_pkg::cmd_t                  cmd,
  output nfsa_pkg::sts_t                  sts,
  input  logic                            in_opcode,
  input  logic [nfsa_pkg::IDX_W-1:0]      in_slot_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nfsa_pkg::STATUS_W-1:0]   out_status,
  output logic [nfsa_pkg::IDX_W-1:0]      out_granted_slot,
  output logic [nfsa_pkg::CNT_OUT_W-1:0]  out_used_count,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  import nfsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // request
  logic             req_op_r;
  logic [IDX_W-1:0] req_idx_r;

  // pool state
  logic [IW-1:0] clr_addr_r;
  logic [IW-1:0] scan_ptr_r;
  logic [CW-1:0] used_r;

  // scan pipeline
  logic [IW-1:0] scan_addr_r;
  logic [IW-1:0] chk_addr_r;
  logic          chk_vld_r;

  // pending result
  status_t       res_code_r;
  kind_t         res_kind_r;
  logic [IW-1:0] res_slot_r;

  // output stage
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [IDX_W-1:0]     out_slot_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_empty_r;
  logic                 out_full_r;

  logic [IW+IDX_W-1:0]     idx_ext;
  logic [IW+IDX_W-1:0]     slot_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;
  logic [IW-1:0]           rel_addr;
  logic [IW-1:0]           scan_inc;
  logic [CW-1:0]           used_nxt;
  logic                    out_free;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [0:0]    ram_rdata;

  assign idx_ext  = {{IW{1'b0}}, req_idx_r};
  assign rel_addr = idx_ext[IW-1:0];
  assign scan_inc = (scan_addr_r == IW'(SLOTS - 1)) ? '0 : scan_addr_r + IW'(1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (res_kind_r)
      K_ALLOC:   used_nxt = used_r + CW'(1);
      K_RELEASE: used_nxt = used_r - CW'(1);
      default:   used_nxt = used_r;
    endcase
  end

  assign slot_ext = {{IDX_W{1'b0}}, res_slot_r};
  assign cnt_ext  = {{CNT_OUT_W{1'b0}}, used_nxt};

  // flag = 1 means slot free
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 1'b1;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd.commit && res_kind_r == K_ALLOC) begin
      ram_we    = 1'b1;
      ram_waddr = res_slot_r;
      ram_wdata = 1'b0;
    end else if (cmd.commit && res_kind_r == K_RELEASE) begin
      ram_we    = 1'b1;
      ram_waddr = rel_addr;
    end
  end

  assign ram_raddr = cmd.rd_scan ? scan_addr_r : rel_addr;

  nfsa_ram #(
    .WIDTH(1),
    .DEPTH(SLOTS)
  ) u_flags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      scan_ptr_r  <= '0;
      used_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + IW'(1);
      end
      if (cmd.scan_start) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_vld_r <= 1'b1;
      end
      if (cmd.commit) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
        if (res_kind_r == K_ALLOC) begin
          scan_ptr_r <= res_slot_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r  <= in_opcode;
      req_idx_r <= in_slot_index;
    end
    if (cmd.scan_start) begin
      scan_addr_r <= scan_ptr_r;
    end else if (cmd.scan_step) begin
      scan_addr_r <= scan_inc;
      chk_addr_r  <= scan_addr_r;
    end
    if (cmd.res_load) begin
      res_code_r <= cmd.res_code;
      res_kind_r <= cmd.res_kind;
      res_slot_r <= chk_addr_r;
    end
    if (cmd.commit) begin
      out_status_r <= res_code_r;
      out_slot_r   <= (res_kind_r == K_ALLOC) ? slot_ext[IDX_W-1:0] : '0;
      out_cnt_r    <= cnt_ext[CNT_OUT_W-1:0];
      out_empty_r  <= (used_nxt == '0);
      out_full_r   <= (used_nxt == CW'(SLOTS));
    end
  end

  always_comb begin
    sts.clr_last  = (clr_addr_r == IW'(SLOTS - 1));
    sts.req_alloc = (req_op_r == OP_ALLOC);
    sts.full      = (used_r == CW'(SLOTS));
    sts.empty     = (used_r == '0);
    sts.idx_oob   = (32'(req_idx_r) >= 32'(SLOTS));
    sts.chk_free  = ram_rdata[0];
    sts.scan_hit  = chk_vld_r && ram_rdata[0];
    sts.out_free  = out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_slot_r;
  assign out_used_count   = out_cnt_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

endmodule

// ----- rtl/next_fit_slot_allocator.sv -----
// Accept to out_valid: full/empty/out-of-range rejects go from decode straight
//   to the response step, a release reads and checks its flag first, and an
//   allocate scans from the scan pointer past used slots. One item is processed
//   at a time; the allocate scan reads one free flag per cycle from the
//   single-read-port flag RAM. Reset: rst_n synchronous; afterwards a clearing
//   pass marks every slot free while in_ready stays low.
module next_fit_slot_allocator #(
  parameter int SLOTS = nfsa_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [nfsa_pkg::IDX_W-1:0]      in_slot_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nfsa_pkg::STATUS_W-1:0]   out_status,
  output logic [nfsa_pkg::IDX_W-1:0]      out_granted_slot,
  output logic [nfsa_pkg::CNT_OUT_W-1:0]  out_used_count,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  import nfsa_pkg::*;

  // Controller sequences one item at a time: decode, then a pipelined flag
  // scan (allocate), a read-check (release) or a direct reject, then a
  // response step that commits pool state and loads the output register.
  // The output register lets a new item be taken while the last result
  // still waits for out_ready; the response step stalls only if the
  // output register is still occupied and out_ready is low.
  cmd_t cmd;
  sts_t sts;

  nfsa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Datapath: free-flag RAM, scan pointer, used count, result registers.
  nfsa_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_granted_slot(out_granted_slot),
    .out_used_count  (out_used_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule

// ----- rtl/nfsa_checker.sv -----
`include "next_fit_slot_allocator_defines.svh"

module nfsa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [nfsa_pkg::STATUS_W-1:0]   out_status,
  input logic [nfsa_pkg::IDX_W-1:0]      out_granted_slot,
  input logic [nfsa_pkg::CNT_OUT_W-1:0]  out_used_count,
  input logic                            out_is_empty,
  input logic                            out_is_full
);

  import nfsa_pkg::*;

  // stalled result holds
  `NFSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_granted_slot) && $stable(out_used_count))
  // pool cannot be empty and full at once
  `NFSA_ASSERT_IMP(a_not_both, out_valid, !(out_is_empty && out_is_full))
  // only a successful grant carries a slot index
  `NFSA_ASSERT_IMP(a_grant_zero, out_valid && (out_status != ST_OK), out_granted_slot == '0)
  // empty pool reports a zero count
  `NFSA_ASSERT_IMP(a_empty_cnt, out_valid && out_is_empty, out_used_count == '0)

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_granted_slot(out_granted_slot),
  .out_used_count  (out_used_count),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full)
);
